### rtl/prc_pkg.sv
// ----------------------------------------------------------------------------
// prc_pkg
// Shared types and constants of the packet rule classifier.
// ----------------------------------------------------------------------------
package prc_pkg;

  localparam int RULE_SLOTS = 16;
  localparam int IDX_W      = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
  localparam int CNT_W      = 5;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
  localparam logic [15:0] ETYPE_ARP  = 16'h0806;

  localparam logic [0:0] CMD_CLASSIFY = 1'b0;
  localparam logic [0:0] CMD_WRITE    = 1'b1;

  localparam logic [0:0] REG_RULE_COUNT = 1'b0;

  typedef struct packed {
    logic [15:0] eth_type;
    logic [7:0]  ip_protocol;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] src_port;
    logic [15:0] dst_port;
  } rule_t;

  localparam int RULE_W = $bits(rule_t);

  typedef struct packed {
    logic [0:0]  cmd;
    logic [3:0]  rule_index;
    logic [15:0] eth_type;
    logic [7:0]  ip_protocol;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] src_port;
    logic [15:0] dst_port;
  } in_item_t;

  typedef struct packed {
    logic       drop;
    logic [3:0] hit_index;
  } out_item_t;

endpackage

### rtl/prc_if.sv
// ----------------------------------------------------------------------------
// prc_in_if / prc_out_if
// Valid/ready channels carrying classifier input and result transactions.
// ----------------------------------------------------------------------------
interface prc_in_if;
  logic              valid;
  logic              ready;
  prc_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface prc_out_if;
  logic               valid;
  logic               ready;
  prc_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/prc_ram.sv
// ----------------------------------------------------------------------------
// prc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module prc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_W-1:0]    waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic [ADDR_W-1:0]    raddr,
  output logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/prc_match.sv
// ----------------------------------------------------------------------------
// prc_match
// Compare unit: tests one stored rule against the frame key, zero fields
// acting as wildcards; IP fields apply only to IPv4 keys, ports are ignored for ARP.
// ----------------------------------------------------------------------------
module prc_match (
  input  prc_pkg::rule_t rule,
  input  prc_pkg::rule_t key,
  output logic           hit
);

  logic et_ok;
  logic ip_ok;
  logic port_ok;
  logic is_ipv4;
  logic is_arp;

  always_comb begin
    is_ipv4 = (key.eth_type == prc_pkg::ETYPE_IPV4);
    is_arp  = (key.eth_type == prc_pkg::ETYPE_ARP);
    et_ok   = (rule.eth_type == '0) || (rule.eth_type == key.eth_type);
    ip_ok   = !is_ipv4 ||
              (((rule.ip_protocol == '0) || (rule.ip_protocol == key.ip_protocol)) &&
               ((rule.src_ip == '0) || (rule.src_ip == key.src_ip)) &&
               ((rule.dst_ip == '0) || (rule.dst_ip == key.dst_ip)));
    port_ok = is_arp ||
              (((rule.src_port == '0) || (rule.src_port == key.src_port)) &&
               ((rule.dst_port == '0) || (rule.dst_port == key.dst_port)));
    hit     = et_ok && ip_ok && port_ok;
  end

endmodule

### rtl/packet_rule_classifier_top.sv
// ----------------------------------------------------------------------------
// packet_rule_classifier_top
// First-match drop-rule classifier with wildcard fields over a rule table.
// ----------------------------------------------------------------------------
//  channel   direction  handshake       payload
//  in_ch     sink       valid/ready     cmd, rule_index, header or rule fields
//  out_ch    source     valid/ready     drop, hit_index
//  apb       slave      psel/penable    rule_count at byte address 0
//
//  A rule write is answered without a scan; a classify reads at most
//  min(rule_count, 16) rules, one stored rule per cycle through the
//  single RAM read port and shared compare unit; it stops at the first hit.
//  Reset (synchronous) clears the sequencer, the output valid and
//  rule_count; the rule table holds no reset value.
//  A result that meets a stalled output waits in a holding register; the
//  next transaction is taken once the output register is free.
// ----------------------------------------------------------------------------
module packet_rule_classifier_top (
  input  logic                               clk,
  input  logic                               rst,
  prc_in_if.sink                             in_ch,
  prc_out_if.source                          out_ch,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [prc_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [prc_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [prc_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                               pready
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_HOLD = 3'b100
  } state_t;

  state_t                    state;
  logic [prc_pkg::CNT_W-1:0] rule_count;
  prc_pkg::rule_t            key;
  logic [prc_pkg::IDX_W-1:0] scan_idx;
  logic [prc_pkg::IDX_W-1:0] last_idx;
  logic                      out_valid;
  prc_pkg::out_item_t        out_item;
  prc_pkg::out_item_t        pend_item;

  prc_pkg::out_item_t        res_next;
  logic                      accept;
  logic                      out_free;
  logic                      out_load;
  logic                      in_ready;
  logic                      ram_we;
  logic [prc_pkg::IDX_W-1:0] rd_addr;
  logic [prc_pkg::RULE_W-1:0] rd_data;
  prc_pkg::rule_t            wr_rule;
  logic                      rule_hit;
  logic                      cfg_wr;
  logic                      scan_end;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    if (paddr[2] == prc_pkg::REG_RULE_COUNT) begin
      prdata = {{(prc_pkg::CFG_DATA_W - prc_pkg::CNT_W){1'b0}}, rule_count};
    end else begin
      prdata = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rule_count <= '0;
    end else if (cfg_wr && (paddr[2] == prc_pkg::REG_RULE_COUNT)) begin
      rule_count <= pwdata[prc_pkg::CNT_W-1:0];
    end
  end

  // handshakes
  assign out_free    = !out_valid || out_ch.ready;
  assign in_ready    = (state == ST_IDLE) && out_free;
  assign in_ch.ready = in_ready;
  assign accept      = in_ch.valid && in_ready;
  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_item;

  // rule table
  always_comb begin
    wr_rule.eth_type    = in_ch.data.eth_type;
    wr_rule.ip_protocol = in_ch.data.ip_protocol;
    wr_rule.src_ip      = in_ch.data.src_ip;
    wr_rule.dst_ip      = in_ch.data.dst_ip;
    wr_rule.src_port    = in_ch.data.src_port;
    wr_rule.dst_port    = in_ch.data.dst_port;
  end

  assign ram_we  = accept && (in_ch.data.cmd == prc_pkg::CMD_WRITE) &&
                   ({28'd0, in_ch.data.rule_index} < 32'(prc_pkg::RULE_SLOTS));
  assign rd_addr = (state == ST_SCAN) ? prc_pkg::IDX_W'(scan_idx + 1'b1) : '0;

  prc_ram #(
    .WIDTH (prc_pkg::RULE_W),
    .DEPTH (prc_pkg::RULE_SLOTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (prc_pkg::IDX_W'(in_ch.data.rule_index)),
    .wdata (wr_rule),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  prc_match u_match (
    .rule (prc_pkg::rule_t'(rd_data)),
    .key  (key),
    .hit  (rule_hit)
  );

  assign scan_end = rule_hit || (scan_idx == last_idx);

  always_comb begin
    res_next.drop      = rule_hit;
    res_next.hit_index = rule_hit ? 4'(scan_idx) : 4'd0;
  end

  assign out_load = (accept &&
                     ((in_ch.data.cmd == prc_pkg::CMD_WRITE) || (rule_count == '0))) ||
                    ((state == ST_SCAN) && scan_end && out_free) ||
                    ((state == ST_HOLD) && out_free);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if ((in_ch.data.cmd == prc_pkg::CMD_WRITE) || (rule_count == '0)) begin
              out_item <= '0;
            end else begin
              scan_idx <= '0;
              state    <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (scan_end) begin
            if (out_free) begin
              out_item <= res_next;
              state    <= ST_IDLE;
            end else begin
              pend_item <= res_next;
              state     <= ST_HOLD;
            end
          end else begin
            scan_idx <= prc_pkg::IDX_W'(scan_idx + 1'b1);
          end
        end
        ST_HOLD: begin
          if (out_free) begin
            out_item <= pend_item;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // latch the frame key and the scan bounds on acceptance
  always_ff @(posedge clk) begin
    if (accept) begin
      key <= wr_rule;
      if ({27'd0, rule_count} >= 32'(prc_pkg::RULE_SLOTS)) begin
        last_idx <= prc_pkg::IDX_W'(prc_pkg::RULE_SLOTS - 1);
      end else begin
        last_idx <= prc_pkg::IDX_W'(rule_count - 5'd1);
      end
    end
  end

  a_write_result: assert property (@(posedge clk) disable iff (rst)
    (accept && (in_ch.data.cmd == prc_pkg::CMD_WRITE)) |=>
      (out_ch.valid && !out_ch.data.drop && (out_ch.data.hit_index == 4'd0)))
    else $error("rule write did not return a clear result");

  a_miss_index: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.data.drop) |-> (out_ch.data.hit_index == 4'd0))
    else $error("miss reported with a non-zero hit index");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (scan_idx <= last_idx))
    else $error("scan ran past the last active rule");

  a_busy_block: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_SCAN) || (state == ST_HOLD)) |-> !in_ch.ready)
    else $error("input taken while a classify is in flight");

endmodule
